FILE: rtl/assert_macros.svh
// Assertion macros shared by the hue pipeline.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RTH_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define RTH_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication failed");
`else
`define RTH_ASSERT(lbl, clk, rst, prop)
`define RTH_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/rth_pkg.sv
// Types and constants of the hue pipeline.
package rth_pkg;

   localparam int CHANNEL_BITS = 16;
   localparam int HUE_BITS     = 9;
   localparam int NUM_BITS     = CHANNEL_BITS + HUE_BITS;
   localparam int DIV_STAGES   = 3;
   localparam int DIV_STEPS    = HUE_BITS / DIV_STAGES;

   localparam logic [1:0] SECTOR_RED   = 2'd0;
   localparam logic [1:0] SECTOR_GREEN = 2'd1;
   localparam logic [1:0] SECTOR_BLUE  = 2'd2;

   typedef struct packed {
      logic [NUM_BITS-1:0] rem;
      logic [NUM_BITS-1:0] dsh;
      logic [HUE_BITS-1:0] quo;
      logic                grey;
   } div_word_type;

endpackage

FILE: rtl/rgb_to_hue_top.sv
// Top level of the hue pipeline: front end and divider stages.
//
//  channel  direction  handshake            payload
//  req      in         req_valid/req_ready  req_red, req_green, req_blue
//  rsp      out        rsp_valid/rsp_ready  rsp_hue_degrees
//
// One word per cycle while rsp_ready holds; three front-end stages, then three
// divider stages of three quotient bits each, the last one being the output register.
// Reset clears only the stage valid bits.
// Each stage holds its word while the next is full and stalled; bubbles close up.
`include "assert_macros.svh"
module rgb_to_hue_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [rth_pkg::CHANNEL_BITS-1:0] req_red,
   input  logic [rth_pkg::CHANNEL_BITS-1:0] req_green,
   input  logic [rth_pkg::CHANNEL_BITS-1:0] req_blue,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [rth_pkg::HUE_BITS-1:0]     rsp_hue_degrees
);
   import rth_pkg::*;

   logic         stg_valid [DIV_STAGES+1];
   logic         stg_ready [DIV_STAGES+1];
   div_word_type stg_word  [DIV_STAGES+1];
   logic         grey_head;

   rth_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_red    (req_red),
      .in_green  (req_green),
      .in_blue   (req_blue),
      .out_valid (stg_valid[0]),
      .out_ready (stg_ready[0]),
      .out_word  (stg_word[0])
   );

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
      rth_div_stage u_div (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stg_valid[k]),
         .in_ready  (stg_ready[k]),
         .in_word   (stg_word[k]),
         .out_valid (stg_valid[k+1]),
         .out_ready (stg_ready[k+1]),
         .out_word  (stg_word[k+1])
      );
   end

   assign stg_ready[DIV_STAGES] = rsp_ready;
   assign rsp_valid             = stg_valid[DIV_STAGES];
   // grey words divide by zero; force the hue to zero
   assign rsp_hue_degrees = stg_word[DIV_STAGES].grey ? '0 : stg_word[DIV_STAGES].quo;

   assign grey_head = stg_valid[0] && stg_word[0].grey;

   `RTH_ASSERT_IMPL(a_hue_range, clock, reset, rsp_valid, rsp_hue_degrees <= HUE_BITS'(359))
   `RTH_ASSERT_IMPL(a_stall_origin, clock, reset, !req_ready, rsp_valid && !rsp_ready)
   `RTH_ASSERT_IMPL(a_grey_word, clock, reset, grey_head, {stg_word[0].rem, stg_word[0].dsh} == '0)

endmodule

FILE: rtl/rth_front.sv
// Front end: sector pick, delta and numerator over three register stages.
module rth_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  logic [rth_pkg::CHANNEL_BITS-1:0] in_red,
   input  logic [rth_pkg::CHANNEL_BITS-1:0] in_green,
   input  logic [rth_pkg::CHANNEL_BITS-1:0] in_blue,
   output logic                             out_valid,
   input  logic                             out_ready,
   output rth_pkg::div_word_type            out_word
);
   import rth_pkg::*;

   logic                    v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   logic                    rdy1, rdy2, rdy3;
   logic [CHANNEL_BITS-1:0] delta1_ff, delta1_in, mag1_ff, mag1_in;
   logic                    neg1_ff, neg1_in;
   logic [1:0]              sec1_ff, sec1_in;
   logic [NUM_BITS-1:0]     ta2_ff, ta2_in, tb2_ff, tb2_in;
   logic                    neg2_ff, grey2_ff, grey2_in;
   logic [CHANNEL_BITS-1:0] delta2_ff;
   div_word_type            word3_ff, word3_in;

   assign rdy3     = !v3_ff || out_ready;
   assign rdy2     = !v2_ff || rdy3;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;
   assign v1_in    = rdy1 ? in_valid : v1_ff;
   assign v2_in    = rdy2 ? v1_ff : v2_ff;
   assign v3_in    = rdy3 ? v2_ff : v3_ff;

   // stage 1: sector, delta, signed channel difference
   always_comb begin
      logic [CHANNEL_BITS-1:0] hi, lo, x, y;
      if (in_red >= in_green && in_red >= in_blue) begin
         sec1_in = SECTOR_RED;
         hi = in_red;
         x  = in_green;
         y  = in_blue;
      end else if (in_green >= in_blue) begin
         sec1_in = SECTOR_GREEN;
         hi = in_green;
         x  = in_blue;
         y  = in_red;
      end else begin
         sec1_in = SECTOR_BLUE;
         hi = in_blue;
         x  = in_red;
         y  = in_green;
      end
      lo        = (x < y) ? x : y;
      delta1_in = hi - lo;
      neg1_in   = x < y;
      mag1_in   = neg1_in ? (y - x) : (x - y);
   end

   // stage 2: sector offset times delta, sixty times difference
   always_comb begin
      logic [NUM_BITS-1:0] d, m;
      d = NUM_BITS'(delta1_ff);
      m = NUM_BITS'(mag1_ff);
      case (sec1_ff)
         SECTOR_RED:   ta2_in = neg1_ff ? ((d << 8) + (d << 6) + (d << 5) + (d << 3))
                                        : '0;
         SECTOR_GREEN: ta2_in = (d << 6) + (d << 5) + (d << 4) + (d << 3);
         SECTOR_BLUE:  ta2_in = (d << 7) + (d << 6) + (d << 5) + (d << 4);
         default:      ta2_in = '0;
      endcase
      tb2_in   = (m << 6) - (m << 2);
      grey2_in = delta1_ff == '0;
   end

   // stage 3: numerator and aligned divisor
   always_comb begin
      word3_in.rem  = neg2_ff ? (ta2_ff - tb2_ff) : (ta2_ff + tb2_ff);
      word3_in.dsh  = NUM_BITS'(delta2_ff) << (HUE_BITS - 1);
      word3_in.quo  = '0;
      word3_in.grey = grey2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
      if (rdy1) begin
         delta1_ff <= delta1_in;
         mag1_ff   <= mag1_in;
         neg1_ff   <= neg1_in;
         sec1_ff   <= sec1_in;
      end
      if (rdy2) begin
         ta2_ff    <= ta2_in;
         tb2_ff    <= tb2_in;
         neg2_ff   <= neg1_ff;
         grey2_ff  <= grey2_in;
         delta2_ff <= delta1_ff;
      end
      if (rdy3) begin
         word3_ff <= word3_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_word  = word3_ff;

endmodule

FILE: rtl/rth_div_stage.sv
// One stage of the restoring divider: a few quotient bits per stage.
module rth_div_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  rth_pkg::div_word_type in_word,
   output logic                  out_valid,
   input  logic                  out_ready,
   output rth_pkg::div_word_type out_word
);
   import rth_pkg::*;

   logic         valid_ff, valid_in;
   div_word_type word_ff, word_in;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      word_in = in_word;
      for (int i = 0; i < DIV_STEPS; i++) begin
         if (word_in.rem >= word_in.dsh) begin
            word_in.rem = word_in.rem - word_in.dsh;
            word_in.quo = {word_in.quo[HUE_BITS-2:0], 1'b1};
         end else begin
            word_in.quo = {word_in.quo[HUE_BITS-2:0], 1'b0};
         end
         word_in.dsh = word_in.dsh >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_ready) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for the RGB to hue pipeline: directed table, then random words.
`timescale 1ns / 1ps

module tb_top;

   import rth_pkg::*;

   localparam int RESET_CYCLES = 12;
   localparam int RANDOM_WORDS = 1650;
   localparam int QUIET_WORDS  = 200;
   localparam int DRAIN_CYCLES = 24;
   localparam int N_CASES      = 22;
   localparam logic [CHANNEL_BITS-1:0] CH_MAX = '1;

   typedef struct packed {
      logic [CHANNEL_BITS-1:0] red;
      logic [CHANNEL_BITS-1:0] green;
      logic [CHANNEL_BITS-1:0] blue;
      logic                    typed;
      logic [HUE_BITS-1:0]     hue;
   } hue_case_type;

   // typed = 1: hue column is the expected value; otherwise the predictor decides
   localparam hue_case_type HUE_CASES [0:N_CASES-1] = '{
      '{16'h0000, 16'h0000, 16'h0000, 1'b1, 9'd0},
      '{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 9'd0},
      '{16'h1234, 16'h1234, 16'h1234, 1'b1, 9'd0},
      '{16'hFFFF, 16'h0000, 16'h0000, 1'b1, 9'd0},
      '{16'h0000, 16'hFFFF, 16'h0000, 1'b1, 9'd120},
      '{16'h0000, 16'h0000, 16'hFFFF, 1'b1, 9'd240},
      '{16'hFFFF, 16'hFFFF, 16'h0000, 1'b1, 9'd60},
      '{16'h0000, 16'hFFFF, 16'hFFFF, 1'b1, 9'd180},
      '{16'hFFFF, 16'h0000, 16'hFFFF, 1'b1, 9'd300},
      '{16'h0001, 16'h0000, 16'h0000, 1'b1, 9'd0},
      '{16'h0000, 16'h0001, 16'h0000, 1'b1, 9'd120},
      '{16'h0000, 16'h0000, 16'h0001, 1'b1, 9'd240},
      '{16'hFFFF, 16'h0000, 16'h0001, 1'b0, 9'd0},
      '{16'hFFFF, 16'hFFFE, 16'hFFFF, 1'b0, 9'd0},
      '{16'h8000, 16'h4000, 16'h0000, 1'b0, 9'd0},
      '{16'hFFFE, 16'hFFFF, 16'hFFFF, 1'b0, 9'd0},
      '{16'h0000, 16'h0001, 16'hFFFF, 1'b0, 9'd0},
      '{16'hAAAA, 16'h5555, 16'hFFFF, 1'b0, 9'd0},
      '{16'h5555, 16'hAAAA, 16'h0000, 1'b0, 9'd0},
      '{16'h0001, 16'hFFFF, 16'h0000, 1'b0, 9'd0},
      '{16'hFFFF, 16'h0001, 16'h0000, 1'b0, 9'd0},
      '{16'h0000, 16'hFFFF, 16'h0001, 1'b0, 9'd0}
   };

   logic                    clock     = 1'b0;
   logic                    reset     = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [CHANNEL_BITS-1:0] req_red   = '0;
   logic [CHANNEL_BITS-1:0] req_green = '0;
   logic [CHANNEL_BITS-1:0] req_blue  = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [HUE_BITS-1:0]     rsp_hue_degrees;

   logic [HUE_BITS-1:0] hue_expected_q [$];
   logic [HUE_BITS-1:0] hue_want;
   int                  errors     = 0;
   bit                  quiet_tail = 1'b0;

   rgb_to_hue_top u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_red         (req_red),
      .req_green       (req_green),
      .req_blue        (req_blue),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_hue_degrees (rsp_hue_degrees)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #2_000_000;
      $display("** rgb_to_hue_top: FAILED **");
      $finish;
   end

   function automatic logic [HUE_BITS-1:0] hue_of(input logic [CHANNEL_BITS-1:0] r,
                                                  input logic [CHANNEL_BITS-1:0] g,
                                                  input logic [CHANNEL_BITS-1:0] b);
      longint     rr, gg, bb, hi, lo, delta, num;
      logic [1:0] sector;
      rr = r;
      gg = g;
      bb = b;
      hi = rr;
      lo = rr;
      if (gg > hi) hi = gg;
      if (bb > hi) hi = bb;
      if (gg < lo) lo = gg;
      if (bb < lo) lo = bb;
      delta = hi - lo;
      if (delta == 0) return '0;
      if (hi == rr) sector = SECTOR_RED;
      else if (hi == gg) sector = SECTOR_GREEN;
      else sector = SECTOR_BLUE;
      case (sector)
         SECTOR_RED: begin
            num = 60 * (gg - bb);
            if (gg < bb) num += 360 * delta;
         end
         SECTOR_GREEN: num = 60 * (bb - rr) + 120 * delta;
         default:      num = 60 * (rr - gg) + 240 * delta;
      endcase
      return HUE_BITS'(num / delta);
   endfunction

   task automatic send_word(input logic [CHANNEL_BITS-1:0] r,
                            input logic [CHANNEL_BITS-1:0] g,
                            input logic [CHANNEL_BITS-1:0] b,
                            input logic [HUE_BITS-1:0]     hue);
      req_valid <= 1'b1;
      req_red   <= r;
      req_green <= g;
      req_blue  <= b;
      do @(posedge clock); while (!req_ready);
      hue_expected_q.push_back(hue);
   endtask

   task automatic maybe_idle();
      if (!quiet_tail && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
   endtask

   // sender
   initial begin
      logic [CHANNEL_BITS-1:0] r, g, b, top_v, low_v;
      int unsigned             pick;
      @(posedge clock);
      while (reset) @(posedge clock);

      for (int i = 0; i < N_CASES; i++) begin
         r = HUE_CASES[i].red;
         g = HUE_CASES[i].green;
         b = HUE_CASES[i].blue;
         send_word(r, g, b, HUE_CASES[i].typed ? HUE_CASES[i].hue : hue_of(r, g, b));
         maybe_idle();
      end

      for (int i = 0; i < RANDOM_WORDS; i++) begin
         if (i == RANDOM_WORDS - QUIET_WORDS) quiet_tail = 1'b1;
         pick = $urandom_range(0, 9);
         r = CHANNEL_BITS'($urandom);
         g = CHANNEL_BITS'($urandom);
         b = CHANNEL_BITS'($urandom);
         case (pick)
            0: begin
               g = r;
               b = r;
            end
            1, 2: begin
               // two channels share the maximum
               top_v = CHANNEL_BITS'($urandom_range(1, CH_MAX));
               low_v = CHANNEL_BITS'($urandom_range(0, top_v - 1));
               case ($urandom_range(0, 2))
                  0: begin r = top_v; g = top_v; b = low_v; end
                  1: begin r = top_v; g = low_v; b = top_v; end
                  default: begin r = low_v; g = top_v; b = top_v; end
               endcase
            end
            3: begin
               r = CHANNEL_BITS'($urandom_range(0, 15));
               g = CHANNEL_BITS'($urandom_range(0, 15));
               b = CHANNEL_BITS'($urandom_range(0, 15));
            end
            4: begin
               // small delta
               top_v = CHANNEL_BITS'($urandom_range(0, CH_MAX - 8));
               r = top_v + CHANNEL_BITS'($urandom_range(0, 8));
               g = top_v + CHANNEL_BITS'($urandom_range(0, 8));
               b = top_v + CHANNEL_BITS'($urandom_range(0, 8));
            end
            5: begin
               if ($urandom_range(0, 1) == 0) r = $urandom_range(0, 1) ? CH_MAX : '0;
               if ($urandom_range(0, 1) == 0) g = $urandom_range(0, 1) ? CH_MAX : '0;
               if ($urandom_range(0, 1) == 0) b = $urandom_range(0, 1) ? CH_MAX : '0;
            end
            default: ;
         endcase
         send_word(r, g, b, hue_of(r, g, b));
         maybe_idle();
      end

      req_valid <= 1'b0;
      while (hue_expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0 && hue_expected_q.size() == 0) begin
         $display("** rgb_to_hue_top: PASSED **");
      end else begin
         $display("** rgb_to_hue_top: FAILED **");
      end
      $finish;
   end

   // receiver back-pressure
   initial begin
      int unsigned hold;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            hold = $urandom_range(1, 18);
         end else begin
            rsp_ready <= 1'b1;
            hold = $urandom_range(1, 30);
         end
         repeat (hold) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (hue_expected_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected word, expected none, actual hue %0d",
                     $time, rsp_hue_degrees);
         end else begin
            hue_want = hue_expected_q.pop_front();
            if (rsp_hue_degrees !== hue_want) begin
               errors++;
               $display("%0t: hue mismatch, expected %0d, actual %0d",
                        $time, hue_want, rsp_hue_degrees);
            end
         end
      end
   end

endmodule
